FILE: rtl/turtle_path_interpreter_unit_macros.svh
// Assertion macros for the turtle path interpreter checkers.
`ifndef TURTLE_PATH_INTERPRETER_UNIT_MACROS_SVH
`define TURTLE_PATH_INTERPRETER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define TPI_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("turtle path interpreter check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define TPI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("turtle path interpreter check failed");

`endif

FILE: rtl/tpi_pkg.sv
// Shared constants, types and the quarter-wave sine table of the turtle path interpreter.
package tpi_pkg;

	localparam int STACK_DEPTH  = 64;
	localparam int SINE_ENTRIES = 1024;

	localparam int STACK_AW = $clog2(STACK_DEPTH);
	localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
	localparam int SINE_AW  = $clog2(SINE_ENTRIES);

	localparam int SYM_W     = 8;
	localparam int POS_W     = 24;
	localparam int HEAD_W    = 16;
	localparam int STEP_W    = 16;
	localparam int MAG_W     = 17;
	localparam int FRAC_W    = HEAD_W - 2;
	localparam int KIND_W    = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int WORD_W    = 2 * POS_W + HEAD_W;

	localparam int IN_DATA_W  = SYM_W + 2 * POS_W + HEAD_W;
	localparam int OUT_DATA_W = 4 * POS_W;

	localparam logic [SYM_W-1:0]  PUSH_CODE    = 8'd91;
	localparam logic [SYM_W-1:0]  POP_CODE     = 8'd93;
	localparam logic [SYM_W-1:0]  FWD_SYM_RST  = 8'd70;
	localparam logic [SYM_W-1:0]  LEFT_SYM_RST = 8'd43;
	localparam logic [SYM_W-1:0]  RIGHT_SYM_RST = 8'd45;
	localparam logic [STEP_W-1:0] TURN_RST     = 16'd16384;
	localparam logic [STEP_W-1:0] STEP_RST     = 16'd2560;
	localparam logic [HEAD_W-1:0] HEAD_RST     = 16'd1820;
	localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'h4000;
	localparam logic [MAG_W-1:0]  MAG_ONE      = 17'h10000;
	localparam logic [63:0]       HALF_PI_Q30  = 64'd1686629713;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEGMENT   = 2'd0,
		KIND_UNDERFLOW = 2'd1,
		KIND_OVERFLOW  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FWD_SYM    = 3'd0,
		REG_LEFT_SYM   = 3'd1,
		REG_RIGHT_SYM  = 3'd2,
		REG_TURN_STEP  = 3'd3,
		REG_STEP_LEN   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
	} trig_t;

	typedef struct packed {
		logic                      first;
		logic                      move;
		logic                      push_ok;
		logic                      pop_ok;
		logic                      byp_pop;
		logic                      has_res;
		kind_t                     kind;
		logic [STACK_AW-1:0]       waddr;
		logic [HEAD_W-1:0]         h_turn;
		logic signed [POS_W-1:0]   start_x;
		logic signed [POS_W-1:0]   start_y;
	} item_t;

	typedef logic [MAG_W-1:0] sine_tbl_t [SINE_ENTRIES];

	function automatic sine_tbl_t build_sine_tbl();
		sine_tbl_t          tbl;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		int                 i;
		int                 k;
		for (i = 0; i < SINE_ENTRIES; i++) begin
			x    = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
			x2   = (x * x) >> 30;
			term = x;
			sum  = signed'(x);
			for (k = 1; k <= 6; k++) begin
				term = (term * x2) >> 30;
				case (k)
					1: term = term / 6;
					2: term = term / 20;
					3: term = term / 42;
					4: term = term / 72;
					5: term = term / 110;
					6: term = term / 156;
					default: term = term;
				endcase
				if (k[0]) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (unsigned'(sum) + 64'd8192) >> 14;
			if (v > 64'd65536) begin
				v = 64'd65536;
			end
			tbl[i] = v[MAG_W-1:0];
		end
		return tbl;
	endfunction

endpackage

FILE: rtl/tpi_sine_rom.sv
// Quarter-wave sine ROM with registered sine and cosine lookups of one heading.
module tpi_sine_rom (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tpi_pkg::HEAD_W-1:0]  heading,
	output tpi_pkg::trig_t              sin_val,
	output tpi_pkg::trig_t              cos_val
);
	import tpi_pkg::*;

	localparam sine_tbl_t SINE_TBL = build_sine_tbl();
	localparam int PROD_W = FRAC_W + SINE_AW;
	localparam logic [FRAC_W:0] QUARTER_U = (FRAC_W + 1)'(1) << FRAC_W;

	logic [HEAD_W-1:0]  lane_h    [2];
	logic [FRAC_W-1:0]  lane_w    [2];
	logic [FRAC_W:0]    lane_u    [2];
	logic [PROD_W-1:0]  lane_prod [2];
	logic [SINE_AW-1:0] lane_idx  [2];
	logic               lane_full [2];
	logic               lane_neg  [2];

	logic [MAG_W-1:0]   data_q [2];
	logic               full_q [2];
	logic               neg_q  [2];

	always_comb begin
		lane_h[0] = heading;
		lane_h[1] = heading + QUARTER_TURN;
		for (int i = 0; i < 2; i++) begin
			lane_w[i] = lane_h[i][FRAC_W-1:0];
			if (lane_h[i][FRAC_W]) begin
				lane_u[i] = QUARTER_U - {1'b0, lane_w[i]};
			end else begin
				lane_u[i] = {1'b0, lane_w[i]};
			end
			lane_full[i] = (lane_u[i] == QUARTER_U);
			lane_neg[i]  = lane_h[i][FRAC_W+1];
			lane_prod[i] = PROD_W'(lane_u[i][FRAC_W-1:0]) * PROD_W'(SINE_ENTRIES);
			lane_idx[i]  = lane_prod[i][PROD_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				data_q[i] <= SINE_TBL[lane_idx[i]];
				full_q[i] <= lane_full[i];
				neg_q[i]  <= lane_neg[i];
			end
		end
	end

	always_comb begin
		sin_val.mag = full_q[0] ? MAG_ONE : data_q[0];
		sin_val.neg = neg_q[0];
		cos_val.mag = full_q[1] ? MAG_ONE : data_q[1];
		cos_val.neg = neg_q[1];
	end

endmodule

FILE: rtl/tpi_step_unit.sv
// One axis of a forward step: scale by step length, round, add and saturate.
module tpi_step_unit (
	input  logic signed [tpi_pkg::POS_W-1:0]  from_pos,
	input  tpi_pkg::trig_t                    trig,
	input  logic [tpi_pkg::STEP_W-1:0]        step_length,
	output logic signed [tpi_pkg::POS_W-1:0]  to_pos
);
	import tpi_pkg::*;

	localparam int PROD_W  = MAG_W + STEP_W;
	localparam int DELTA_W = PROD_W - STEP_W + 1;
	localparam int SUM_W   = POS_W + 2;
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (STEP_W - 1);

	logic [PROD_W-1:0]       prod;
	logic [PROD_W:0]         rounded;
	logic [DELTA_W-1:0]      delta;
	logic signed [SUM_W-1:0] delta_s;
	logic signed [SUM_W-1:0] sum;
	logic                    ovf;

	always_comb begin
		prod    = PROD_W'(trig.mag) * PROD_W'(step_length);
		rounded = {1'b0, prod} + ROUND_HALF;
		delta   = rounded[PROD_W:STEP_W];
		delta_s = $signed({{(SUM_W - DELTA_W){1'b0}}, delta});
		if (trig.neg) begin
			sum = SUM_W'(from_pos) - delta_s;
		end else begin
			sum = SUM_W'(from_pos) + delta_s;
		end
		ovf = (sum[SUM_W-1:POS_W-1] != {(SUM_W - POS_W + 1){1'b0}}) &&
		      (sum[SUM_W-1:POS_W-1] != {(SUM_W - POS_W + 1){1'b1}});
		if (!ovf) begin
			to_pos = sum[POS_W-1:0];
		end else if (sum[SUM_W-1]) begin
			to_pos = {1'b1, {(POS_W - 1){1'b0}}};
		end else begin
			to_pos = {1'b0, {(POS_W - 1){1'b1}}};
		end
	end

endmodule

FILE: rtl/turtle_path_interpreter_unit.sv
// Top level of the turtle path interpreter: control, stack memory and result register.
//
// Symbols enter on the s_ stream, one item per accepted handshake; s_tuser flags the first
// symbol of a string, which loads the start position and (if nonzero) the start heading.
// Results leave on the m_ stream: a line segment for a forward symbol, or an underflow or
// overflow report for a failed pop or push; other symbols give no result.
// The block takes one item per cycle while s_tready is high. The sine ROM and the stack
// memory, both synchronous memories, are read at the accepting edge; the item is then held
// in the update stage, where position, heading and the stack write are settled, and its
// result is registered in the output register that drives m_tvalid. Heading and a same-entry
// push/pop are bypassed from the update stage into the lookup, and stack depth advances at
// acceptance, so back-to-back symbols never wait on each other.
// A result waits in the output register while m_tready is low; the update stage holds an
// item with a pending result behind it, and s_tready drops only then.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, which the block does not enforce. Reset clears position to zero,
// heading to 1820, stack depth to zero, restores default symbols and steps; stack memory is not cleared.
module turtle_path_interpreter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tpi_pkg::IN_DATA_W-1:0]     s_tdata,   // symbol, start_x, start_y, start_heading
	input  logic [0:0]                        s_tuser,   // first_of_string
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tpi_pkg::OUT_DATA_W-1:0]    m_tdata,   // from_x, from_y, to_x, to_y
	output logic [tpi_pkg::KIND_W-1:0]        m_tuser,   // kind
	input  logic                              cfg_we,
	input  logic [tpi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpi_pkg::CFG_W-1:0]         cfg_data
);
	import tpi_pkg::*;

	logic [SYM_W-1:0]        fwd_sym_q;
	logic [SYM_W-1:0]        left_sym_q;
	logic [SYM_W-1:0]        right_sym_q;
	logic [STEP_W-1:0]       turn_step_q;
	logic [STEP_W-1:0]       step_len_q;

	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic [HEAD_W-1:0]       heading_q;
	logic [DEPTH_W-1:0]      depth_q;

	logic [WORD_W-1:0]       stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0]       stack_rd_q;
	logic [WORD_W-1:0]       byp_word_q;

	logic                    valid_s2;
	item_t                   item_s2;

	logic                    out_valid_q;
	kind_t                   out_kind_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic                    accept;
	logic                    s2_go;
	logic                    out_free;

	logic [SYM_W-1:0]        in_sym;
	logic signed [POS_W-1:0] in_sx;
	logic signed [POS_W-1:0] in_sy;
	logic [HEAD_W-1:0]       in_sh;
	logic                    is_move;
	logic                    is_push;
	logic                    is_pop;
	logic [HEAD_W-1:0]       h_cur;
	logic [HEAD_W-1:0]       h_load;
	logic [HEAD_W-1:0]       h_left;
	logic [STACK_AW-1:0]     pop_addr;
	item_t                   item_s1;

	trig_t                   sin_val;
	trig_t                   cos_val;
	logic [WORD_W-1:0]       pop_word;
	logic signed [POS_W-1:0] from_x;
	logic signed [POS_W-1:0] from_y;
	logic signed [POS_W-1:0] to_x;
	logic signed [POS_W-1:0] to_y;
	logic signed [POS_W-1:0] moved_x;
	logic signed [POS_W-1:0] moved_y;
	logic [WORD_W-1:0]       push_word;

	// handshake
	always_comb begin
		out_free = !out_valid_q || m_tready;
		s2_go    = valid_s2 && (!item_s2.has_res || out_free);
		s_tready = !valid_s2 || s2_go;
		accept   = s_tvalid && s_tready;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_sym_q   <= FWD_SYM_RST;
			left_sym_q  <= LEFT_SYM_RST;
			right_sym_q <= RIGHT_SYM_RST;
			turn_step_q <= TURN_RST;
			step_len_q  <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FWD_SYM:   fwd_sym_q   <= cfg_data[SYM_W-1:0];
				REG_LEFT_SYM:  left_sym_q  <= cfg_data[SYM_W-1:0];
				REG_RIGHT_SYM: right_sym_q <= cfg_data[SYM_W-1:0];
				REG_TURN_STEP: turn_step_q <= cfg_data[STEP_W-1:0];
				REG_STEP_LEN:  step_len_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// lookup stage
	always_comb begin
		in_sym = s_tdata[SYM_W-1:0];
		in_sx  = s_tdata[SYM_W +: POS_W];
		in_sy  = s_tdata[SYM_W + POS_W +: POS_W];
		in_sh  = s_tdata[SYM_W + 2 * POS_W +: HEAD_W];

		is_move = (in_sym == fwd_sym_q);
		is_push = (in_sym == PUSH_CODE);
		is_pop  = (in_sym == POP_CODE);

		if (valid_s2) begin
			h_cur = item_s2.pop_ok ? pop_word[HEAD_W-1:0] : item_s2.h_turn;
		end else begin
			h_cur = heading_q;
		end
		h_load = (s_tuser[0] && (in_sh != '0)) ? in_sh : h_cur;
		h_left = (in_sym == left_sym_q) ? h_load + turn_step_q : h_load;

		item_s1.first   = s_tuser[0];
		item_s1.move    = is_move;
		item_s1.push_ok = is_push && (depth_q != DEPTH_W'(STACK_DEPTH));
		item_s1.pop_ok  = is_pop && (depth_q != '0);
		item_s1.byp_pop = valid_s2 && item_s2.push_ok && item_s1.pop_ok;
		item_s1.has_res = is_move || (is_push && !item_s1.push_ok) ||
		                  (is_pop && !item_s1.pop_ok);
		if (is_move) begin
			item_s1.kind = KIND_SEGMENT;
		end else if (is_push) begin
			item_s1.kind = KIND_OVERFLOW;
		end else begin
			item_s1.kind = KIND_UNDERFLOW;
		end
		item_s1.waddr   = depth_q[STACK_AW-1:0];
		item_s1.h_turn  = (in_sym == right_sym_q) ? h_left - turn_step_q : h_left;
		item_s1.start_x = in_sx;
		item_s1.start_y = in_sy;

		pop_addr = STACK_AW'(depth_q - DEPTH_W'(1));
	end

	tpi_sine_rom u_rom (
		.clk     (clk),
		.en      (accept),
		.heading (h_load),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			depth_q  <= '0;
		end else begin
			if (accept) begin
				valid_s2 <= 1'b1;
			end else if (s2_go) begin
				valid_s2 <= 1'b0;
			end
			if (accept && item_s1.push_ok) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (accept && item_s1.pop_ok) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s2 <= item_s1;
		end
	end

	// update stage
	always_comb begin
		pop_word = item_s2.byp_pop ? byp_word_q : stack_rd_q;
		from_x   = item_s2.first ? item_s2.start_x : pos_x_q;
		from_y   = item_s2.first ? item_s2.start_y : pos_y_q;
		moved_x  = item_s2.move ? to_x : from_x;
		moved_y  = item_s2.move ? to_y : from_y;
		push_word = {moved_x, moved_y, item_s2.h_turn};
	end

	tpi_step_unit u_step_x (
		.from_pos    (from_x),
		.trig        (cos_val),
		.step_length (step_len_q),
		.to_pos      (to_x)
	);

	tpi_step_unit u_step_y (
		.from_pos    (from_y),
		.trig        (sin_val),
		.step_length (step_len_q),
		.to_pos      (to_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= HEAD_RST;
		end else if (s2_go) begin
			if (item_s2.pop_ok) begin
				pos_x_q   <= pop_word[WORD_W-1 -: POS_W];
				pos_y_q   <= pop_word[HEAD_W +: POS_W];
				heading_q <= pop_word[HEAD_W-1:0];
			end else begin
				pos_x_q   <= moved_x;
				pos_y_q   <= moved_y;
				heading_q <= item_s2.h_turn;
			end
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (s2_go && item_s2.push_ok) begin
			stack_mem[item_s2.waddr] <= push_word;
		end
		if (accept) begin
			stack_rd_q <= stack_mem[pop_addr];
			byp_word_q <= push_word;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go && item_s2.has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && item_s2.has_res) begin
			out_kind_q <= item_s2.kind;
			if (item_s2.kind == KIND_SEGMENT) begin
				out_data_q <= {to_y, to_x, from_y, from_x};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

endmodule

FILE: rtl/tpi_checker.sv
// Port-level checker of the turtle path interpreter and its bind.
`include "turtle_path_interpreter_unit_macros.svh"

module tpi_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tpi_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [tpi_pkg::KIND_W-1:0]      m_tuser
);
	import tpi_pkg::*;

	`TPI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`TPI_ASSERT_IMPLY(a_err_zero, m_tvalid && (m_tuser != KIND_SEGMENT), m_tdata == '0)
	`TPI_ASSERT_IMPLY(a_reset_empty, !$past(arst_n), !m_tvalid)
	`TPI_ASSERT_IMPLY(a_res_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind turtle_path_interpreter_unit tpi_checker u_tpi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
